>>> design/smf_pkg.sv
// shared types, constants and microcode for the stereo multimode filter
`default_nettype none
package smf_pkg;

	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic [16:0]        env_gain;
	} smf_in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               audible;
	} smf_out_t;

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_BYPASS    = 3'd0;
	localparam mode_t MODE_LADDER    = 3'd1;
	localparam mode_t MODE_PAIR      = 3'd2;
	localparam mode_t MODE_SVF_LOW   = 3'd3;
	localparam mode_t MODE_SVF_BAND  = 3'd4;
	localparam mode_t MODE_SVF_HIGH  = 3'd5;
	localparam mode_t MODE_ONEPOLE   = 3'd6;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_CUTOFF = 2'd1;
	localparam logic [1:0] REG_RES    = 2'd2;

	localparam logic [15:0] CUT_MIN     = 16'd66;
	localparam logic [15:0] CUT_MAX     = 16'd65470;
	localparam logic [16:0] UNITY_Q16   = 17'd65536;
	localparam logic [15:0] NINE_TENTHS = 16'd58982;
	localparam int          AUDIBLE_LIMIT = 6871947;

	typedef enum logic [3:0] {
		SRC_ZERO, SRC_IN, SRC_TMP, SRC_Y,
		SRC_L0, SRC_L1, SRC_L2, SRC_L3,
		SRC_HP0, SRC_HP1, SRC_LP0, SRC_LP1,
		SRC_SV0, SRC_SV1, SRC_OP
	} src_t;

	typedef enum logic [2:0] {
		COEF_P, COEF_K4, COEF_K2, COEF_Q, COEF_GAIN
	} coef_t;

	// one op: dst = sat(c1 - c2 +/- round((a - b) * coef))
	typedef struct packed {
		src_t  a;
		src_t  b;
		coef_t coef;
		src_t  c1;
		src_t  c2;
		logic  neg;
		src_t  dst;
	} uop_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic div_start;
		logic div_wb;
		logic gain_acc;
		logic swap;
		logic push;
		logic chan;
		uop_t op;
	} smf_cmd_t;

	typedef struct packed {
		logic  div_busy;
		mode_t mode;
	} smf_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_DIVLD, ST_DIV, ST_GMUL, ST_GACC, ST_DONE
	} state_t;

	function automatic uop_t mk(input src_t a, input src_t b, input coef_t cf,
			input src_t c1, input src_t c2, input logic ng, input src_t d);
		uop_t u;
		u.a = a; u.b = b; u.coef = cf; u.c1 = c1; u.c2 = c2; u.neg = ng; u.dst = d;
		return u;
	endfunction

	function automatic uop_t gain_uop();
		return mk(SRC_Y, SRC_ZERO, COEF_GAIN, SRC_ZERO, SRC_ZERO, 1'b0, SRC_ZERO);
	endfunction

	function automatic logic [3:0] prog_len(input mode_t m);
		logic [3:0] n;
		case (m) inside
			MODE_LADDER:                               n = 4'd10;
			MODE_PAIR:                                 n = 4'd7;
			MODE_SVF_LOW, MODE_SVF_BAND, MODE_SVF_HIGH: n = 4'd3;
			MODE_ONEPOLE:                              n = 4'd1;
			default:                                   n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic uop_t uop_at(input mode_t m, input logic [3:0] step);
		uop_t u;
		logic [3:0] s;
		u = mk(SRC_ZERO, SRC_ZERO, COEF_P, SRC_ZERO, SRC_ZERO, 1'b0, SRC_ZERO);
		s = (step >= 4'd5) ? step - 4'd5 : step;
		case (m) inside
			MODE_LADDER: begin
				case (s)
					4'd0: u = mk(SRC_L3, SRC_ZERO, COEF_K4, SRC_IN, SRC_ZERO, 1'b1, SRC_TMP);
					4'd1: u = mk(SRC_TMP, SRC_L0, COEF_P, SRC_L0, SRC_ZERO, 1'b0, SRC_L0);
					4'd2: u = mk(SRC_L0, SRC_L1, COEF_P, SRC_L1, SRC_ZERO, 1'b0, SRC_L1);
					4'd3: u = mk(SRC_L1, SRC_L2, COEF_P, SRC_L2, SRC_ZERO, 1'b0, SRC_L2);
					default: u = mk(SRC_L2, SRC_L3, COEF_P, SRC_L3, SRC_ZERO, 1'b0, SRC_L3);
				endcase
			end
			MODE_PAIR: begin
				case (step)
					4'd0: u = mk(SRC_ZERO, SRC_ZERO, COEF_P, SRC_IN, SRC_HP0, 1'b0, SRC_TMP);
					4'd1: u = mk(SRC_TMP, SRC_ZERO, COEF_P, SRC_HP0, SRC_ZERO, 1'b0, SRC_HP0);
					4'd2: u = mk(SRC_HP1, SRC_ZERO, COEF_K2, SRC_TMP, SRC_ZERO, 1'b1, SRC_TMP);
					4'd3: u = mk(SRC_TMP, SRC_HP1, COEF_P, SRC_HP1, SRC_ZERO, 1'b0, SRC_HP1);
					4'd4: u = mk(SRC_LP1, SRC_ZERO, COEF_K2, SRC_TMP, SRC_ZERO, 1'b1, SRC_TMP);
					4'd5: u = mk(SRC_TMP, SRC_LP0, COEF_P, SRC_LP0, SRC_ZERO, 1'b0, SRC_LP0);
					default: u = mk(SRC_LP0, SRC_LP1, COEF_P, SRC_LP1, SRC_ZERO, 1'b0, SRC_LP1);
				endcase
			end
			MODE_SVF_LOW, MODE_SVF_BAND, MODE_SVF_HIGH: begin
				case (step)
					4'd0: u = mk(SRC_SV1, SRC_ZERO, COEF_Q, SRC_IN, SRC_SV0, 1'b1, SRC_TMP);
					4'd1: u = mk(SRC_TMP, SRC_ZERO, COEF_P, SRC_SV1, SRC_ZERO, 1'b0, SRC_SV1);
					default: u = mk(SRC_SV1, SRC_ZERO, COEF_P, SRC_SV0, SRC_ZERO, 1'b0, SRC_SV0);
				endcase
			end
			MODE_ONEPOLE: u = mk(SRC_IN, SRC_OP, COEF_P, SRC_OP, SRC_ZERO, 1'b0, SRC_OP);
			default: ;
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

>>> design/smf_ctrl.sv
// sequencer for the filter microcode, divider and gain steps
`default_nettype none
module smf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire smf_pkg::smf_stat_t stat,
	output smf_pkg::smf_cmd_t     cmd
);
	import smf_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] step_q;
	logic       chan_q;
	logic       out_valid_q;
	logic [3:0] len;
	logic       last;
	logic       bypass;

	assign len    = prog_len(stat.mode);
	assign last   = (step_q == len - 4'd1);
	assign bypass = (len == 4'd0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = bypass ? ST_GMUL : ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC: begin
				if (!last) state_d = ST_MUL;
				else if (stat.mode == MODE_LADDER) state_d = ST_DIVLD;
				else state_d = ST_GMUL;
			end
			ST_DIVLD: state_d = ST_DIV;
			ST_DIV:   if (!stat.div_busy) state_d = ST_GMUL;
			ST_GMUL:  state_d = ST_GACC;
			ST_GACC: begin
				if (chan_q) state_d = ST_DONE;
				else state_d = bypass ? ST_GMUL : ST_MUL;
			end
			ST_DONE:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.chan = chan_q;
		cmd.op   = uop_at(stat.mode, step_q);
		unique case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_MUL:   cmd.mul = 1'b1;
			ST_ACC:   cmd.acc = 1'b1;
			ST_DIVLD: cmd.div_start = 1'b1;
			ST_DIV:   cmd.div_wb = !stat.div_busy;
			ST_GMUL: begin
				cmd.mul = 1'b1;
				cmd.op  = gain_uop();
			end
			ST_GACC: begin
				cmd.gain_acc = 1'b1;
				cmd.swap     = 1'b1;
			end
			ST_DONE:  cmd.push = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			chan_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				step_q <= '0;
				chan_q <= 1'b0;
			end else if (state_q == ST_ACC && !last) begin
				step_q <= step_q + 4'd1;
			end else if (state_q == ST_GACC) begin
				step_q <= '0;
				chan_q <= 1'b1;
			end
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

>>> design/smf_datapath.sv
// filter state banks, shared multiplier, divider, gain and output register
`default_nettype none
module smf_datapath #(
	parameter int STATE_WIDTH = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [16:0]        cfg_data,
	input  wire smf_pkg::smf_in_t   in_data,
	input  wire smf_pkg::smf_cmd_t  cmd,
	output smf_pkg::smf_stat_t      stat,
	output smf_pkg::smf_out_t       out_data
);
	import smf_pkg::*;

	localparam int SW = STATE_WIDTH;
	localparam int DW = SW + 1;
	localparam int PW = DW + 20;
	localparam int AW = SW + 8;
	localparam int NW = SW + 16;
	localparam int CW = $clog2(NW + 1);
	localparam logic signed [PW-1:0] AUD_HI = PW'(AUDIBLE_LIMIT);
	localparam logic signed [PW-1:0] AUD_LO = -AUD_HI;
	localparam logic signed [SW:0]   O_HI = (SW+1)'(32767);
	localparam logic signed [SW:0]   O_LO = -O_HI - 1;

	function automatic logic signed [SW-1:0] sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
		lo = ~hi;
		if (v > hi) return hi[SW-1:0];
		if (v < lo) return lo[SW-1:0];
		return v[SW-1:0];
	endfunction

	// configuration
	mode_t       mode_q;
	logic [15:0] cutoff_q;
	logic [16:0] res_q;

	// per-item coefficients
	logic [15:0] p_q;
	logic [18:0] k4_q;
	logic [17:0] k2_q;
	logic [16:0] q_q;
	logic [16:0] g_q;

	// current channel bank and the other channel's bank
	logic signed [SW-1:0] in_q, in_alt_q, tmp_q;
	logic signed [SW-1:0] lad_q [4];
	logic signed [SW-1:0] lad_alt_q [4];
	logic signed [SW-1:0] hp_q [2];
	logic signed [SW-1:0] hp_alt_q [2];
	logic signed [SW-1:0] lp_q [2];
	logic signed [SW-1:0] lp_alt_q [2];
	logic signed [SW-1:0] sv_q [2];
	logic signed [SW-1:0] sv_alt_q [2];
	logic signed [SW-1:0] op_q, op_alt_q;

	logic signed [PW-1:0] prod_s1;

	logic [NW-1:0] num_q;
	logic [18:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;

	logic signed [15:0] stg_l_q, stg_r_q;
	logic               stg_aud_q;
	smf_out_t           out_q;

	// load-time clamps
	logic [15:0] p_c;
	logic [16:0] r_c, g_c;
	logic [32:0] q_sum;
	logic signed [AW-1:0] xl, xr;

	assign p_c = (cutoff_q < CUT_MIN) ? CUT_MIN : (cutoff_q > CUT_MAX) ? CUT_MAX : cutoff_q;
	assign r_c = (res_q > UNITY_Q16) ? UNITY_Q16 : res_q;
	assign g_c = (in_data.env_gain > UNITY_Q16) ? UNITY_Q16 : in_data.env_gain;
	assign q_sum = 33'(r_c) * 33'(NINE_TENTHS) + 33'd32768;
	assign xl = AW'(in_data.left_in) <<< 5;
	assign xr = AW'(in_data.right_in) <<< 5;

	// filter output for the selected mode
	logic signed [SW-1:0] y_v;
	always_comb begin
		case (mode_q) inside
			MODE_LADDER, MODE_SVF_HIGH: y_v = tmp_q;
			MODE_PAIR:                  y_v = lp_q[1];
			MODE_SVF_LOW:               y_v = sv_q[0];
			MODE_SVF_BAND:              y_v = sv_q[1];
			MODE_ONEPOLE:               y_v = op_q;
			default:                    y_v = in_q;
		endcase
	end

	function automatic logic signed [SW-1:0] rd(input src_t s);
		logic signed [SW-1:0] v;
		case (s)
			SRC_IN:  v = in_q;
			SRC_TMP: v = tmp_q;
			SRC_Y:   v = y_v;
			SRC_L0:  v = lad_q[0];
			SRC_L1:  v = lad_q[1];
			SRC_L2:  v = lad_q[2];
			SRC_L3:  v = lad_q[3];
			SRC_HP0: v = hp_q[0];
			SRC_HP1: v = hp_q[1];
			SRC_LP0: v = lp_q[0];
			SRC_LP1: v = lp_q[1];
			SRC_SV0: v = sv_q[0];
			SRC_SV1: v = sv_q[1];
			SRC_OP:  v = op_q;
			default: v = '0;
		endcase
		return v;
	endfunction

	// multiply phase
	logic signed [SW-1:0] a_v, b_v;
	logic signed [DW-1:0] diff;
	logic signed [19:0]   coef_v;
	assign a_v  = rd(cmd.op.a);
	assign b_v  = rd(cmd.op.b);
	assign diff = DW'(a_v) - DW'(b_v);
	always_comb begin
		case (cmd.op.coef)
			COEF_K4:   coef_v = {1'b0, k4_q};
			COEF_K2:   coef_v = {2'b0, k2_q};
			COEF_Q:    coef_v = {3'b0, q_q};
			COEF_GAIN: coef_v = {3'b0, g_q};
			default:   coef_v = {4'b0, p_q};
		endcase
	end

	// accumulate phase, round to nearest with ties up
	logic signed [PW:0]     rsum, gsum;
	logic signed [PW-16:0]  rnd;
	logic signed [AW-1:0]   asum;
	logic signed [SW-1:0]   res_v;
	logic signed [SW:0]     o_v;
	logic signed [15:0]     o_sat;
	logic                   loud;
	assign rsum  = {prod_s1[PW-1], prod_s1} + (PW+1)'(32768);
	assign rnd   = rsum[PW:16];
	assign asum  = AW'(rd(cmd.op.c1)) - AW'(rd(cmd.op.c2))
		+ (cmd.op.neg ? -AW'(rnd) : AW'(rnd));
	assign res_v = sat(asum);
	assign gsum  = {prod_s1[PW-1], prod_s1} + (PW+1)'(1 << 20);
	assign o_v   = gsum[PW:21];
	assign o_sat = (o_v > O_HI) ? 16'sh7FFF : (o_v < O_LO) ? 16'sh8000 : o_v[15:0];
	assign loud  = (prod_s1 > AUD_HI) || (prod_s1 < AUD_LO);

	// restoring divider for the ladder's 1/(1+k) scaling
	logic [19:0]   trial, den;
	logic          fits;
	logic [SW-1:0] abs_l3;
	logic [SW:0]   qv, qres;
	assign trial  = {rem_q, num_q[NW-1]};
	assign den    = 20'(UNITY_Q16) + 20'(k4_q);
	assign fits   = (trial >= den);
	assign abs_l3 = lad_q[3][SW-1] ? SW'(-lad_q[3]) : lad_q[3];
	assign qv     = {1'b0, num_q[SW-1:0]};
	assign qres   = neg_q ? -qv : qv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BYPASS;
			cutoff_q <= 16'd32768;
			res_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[2:0];
					REG_CUTOFF: cutoff_q <= cfg_data[15:0];
					REG_RES:    res_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.div_start) cnt_q <= CW'(NW);
			else if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				lad_q[i]     <= '0;
				lad_alt_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				hp_q[i] <= '0; hp_alt_q[i] <= '0;
				lp_q[i] <= '0; lp_alt_q[i] <= '0;
				sv_q[i] <= '0; sv_alt_q[i] <= '0;
			end
			op_q     <= '0;
			op_alt_q <= '0;
		end else if (cmd.swap) begin
			for (int i = 0; i < 4; i++) begin
				lad_q[i]     <= lad_alt_q[i];
				lad_alt_q[i] <= lad_q[i];
			end
			for (int i = 0; i < 2; i++) begin
				hp_q[i] <= hp_alt_q[i]; hp_alt_q[i] <= hp_q[i];
				lp_q[i] <= lp_alt_q[i]; lp_alt_q[i] <= lp_q[i];
				sv_q[i] <= sv_alt_q[i]; sv_alt_q[i] <= sv_q[i];
			end
			op_q     <= op_alt_q;
			op_alt_q <= op_q;
		end else if (cmd.acc) begin
			case (cmd.op.dst)
				SRC_L0:  lad_q[0] <= res_v;
				SRC_L1:  lad_q[1] <= res_v;
				SRC_L2:  lad_q[2] <= res_v;
				SRC_L3:  lad_q[3] <= res_v;
				SRC_HP0: hp_q[0]  <= res_v;
				SRC_HP1: hp_q[1]  <= res_v;
				SRC_LP0: lp_q[0]  <= res_v;
				SRC_LP1: lp_q[1]  <= res_v;
				SRC_SV0: sv_q[0]  <= res_v;
				SRC_SV1: sv_q[1]  <= res_v;
				SRC_OP:  op_q     <= res_v;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q     <= sat(xl);
			in_alt_q <= sat(xr);
			p_q      <= p_c;
			k4_q     <= {r_c, 2'b0};
			k2_q     <= {r_c, 1'b0};
			q_q      <= UNITY_Q16 - q_sum[32:16];
			g_q      <= g_c;
		end else if (cmd.swap) begin
			in_q     <= in_alt_q;
			in_alt_q <= in_q;
		end
		if (cmd.acc && cmd.op.dst == SRC_TMP) tmp_q <= res_v;
		else if (cmd.div_wb) tmp_q <= qres[SW-1:0];
		if (cmd.mul) prod_s1 <= PW'(diff) * PW'(coef_v);
		if (cmd.div_start) begin
			num_q <= {abs_l3, 16'b0};
			rem_q <= '0;
			neg_q <= lad_q[3][SW-1];
		end else if (cnt_q != '0) begin
			rem_q <= fits ? 19'(trial - den) : trial[18:0];
			num_q <= {num_q[NW-2:0], fits};
		end
		if (cmd.gain_acc) begin
			if (cmd.chan) begin
				stg_r_q   <= o_sat;
				stg_aud_q <= stg_aud_q | loud;
			end else begin
				stg_l_q   <= o_sat;
				stg_aud_q <= loud;
			end
		end
		if (cmd.push) begin
			out_q.left_out  <= stg_l_q;
			out_q.right_out <= stg_r_q;
			out_q.audible   <= stg_aud_q;
		end
	end

	assign stat.div_busy = (cnt_q != '0);
	assign stat.mode     = mode_q;
	assign out_data      = out_q;
endmodule
`default_nettype wire

>>> design/stereo_multimode_filter.sv
// stereo multimode filter top level: sequencer plus datapath
// each request carries a stereo pair; each channel runs N ops of the mode's microcode (bypass 0,
// one-pole 1, svf 3, hp+lp pair 7, ladder 10), each a multiply then an accumulate step, then a
// gain multiply and accumulate; the ladder also runs its bit-serial divider per channel. one item
// in flight: a new request is taken only after the last result is pushed, which waits while a
// result is still pending; the shared multiplier and the one-bit-per-cycle divider set the pace.
// reset clears all filter state and the registers (mode bypass, cutoff 0.5, no resonance)
`default_nettype none
module stereo_multimode_filter #(
	parameter int STATE_WIDTH = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire smf_pkg::smf_in_t   in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output smf_pkg::smf_out_t       out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [16:0]        cfg_data
);
	import smf_pkg::*;

	smf_cmd_t  cmd;
	smf_stat_t stat;

	assign cfg_ready = 1'b1;

	smf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	smf_datapath #(.STATE_WIDTH(STATE_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !in_ready)
		else $error("divider running while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid || out_ready))
		else $error("result register overwritten");
endmodule
`default_nettype wire
